// ----- sv/assert_macros.svh -----
// Assertion macros used by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies another at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies another at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ----- sv/lot_pkg.sv -----
// ----------------------------------------------------------------------------
// lot_pkg
// Types and constants of the lock ownership tracker.
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam int OP_BITS = 3;
    localparam int FIELD_KEY_BITS = 64;
    localparam int OUT_TSLOT_BITS = 4;
    localparam int OUT_LSLOT_BITS = 5;

    typedef enum logic [2:0] {
        OP_LOCK_TRY    = 3'd0,
        OP_LOCK_DONE   = 3'd1,
        OP_UNLOCK_TRY  = 3'd2,
        OP_UNLOCK_DONE = 3'd3,
        OP_HELD        = 3'd4,
        OP_OWNER       = 3'd5,
        OP_WANTED      = 3'd6,
        OP_HIGHEST     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_FETCH,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [OP_BITS-1:0]        operation;
        logic [FIELD_KEY_BITS-1:0] thread_key;
        logic [FIELD_KEY_BITS-1:0] lock_key;
        logic                      success;
    } req_t;

    typedef struct packed {
        logic [OUT_TSLOT_BITS-1:0] thread_slot;
        logic                      thread_found;
        logic [OUT_LSLOT_BITS-1:0] lock_slot;
        logic                      lock_found;
        logic                      held;
        logic                      owner_valid;
        logic [FIELD_KEY_BITS-1:0] owner_thread;
        logic                      wanted_valid;
        logic [FIELD_KEY_BITS-1:0] wanted_lock;
        logic                      highest_valid;
        logic [OUT_LSLOT_BITS-1:0] highest_slot;
    } rsp_t;

endpackage

// ----- sv/lot_if.sv -----
// ----------------------------------------------------------------------------
// lot_if
// Valid/ready channel carrying one request or one response.
// ----------------------------------------------------------------------------
interface lot_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/lot_key_table.sv -----
// ----------------------------------------------------------------------------
// lot_key_table
// Insert-or-find key table held in a synchronous memory. A search reads one
// entry per cycle and inserts the key at the end when it is absent and room
// is left.
// ----------------------------------------------------------------------------
module lot_key_table
    import lot_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [KEY_BITS-1:0]      key,
    output logic                     busy,
    output logic                     found,
    output logic [$clog2(DEPTH)-1:0] slot,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [KEY_BITS-1:0]      rd_key
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0] mem [DEPTH];
    logic [KEY_BITS-1:0] mem_q;
    logic [CW-1:0]       total_reg;
    logic [CW-1:0]       idx_reg;
    logic                busy_reg;
    logic                wait_reg;
    logic [AW-1:0]       slot_reg;
    logic                found_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [AW-1:0]       scan_addr;
    logic                hit;
    logic                at_end;

    // Search address during a search, external address otherwise.
    assign scan_addr = busy_reg ? idx_reg[AW-1:0] : rd_addr;
    assign hit    = wait_reg && (CW'(idx_reg - 1'b1) < total_reg) && (mem_q == key_reg);
    assign at_end = wait_reg && (idx_reg >= total_reg);

    // Memory read and insertion write.
    always_ff @(posedge clk)
    begin
        mem_q <= mem[scan_addr];
        if (busy_reg && !hit && at_end && total_reg < CW'(DEPTH) && key_reg != '0)
        begin
            mem[total_reg[AW-1:0]] <= key_reg;
        end
    end

    // Slots fill in order, so used entries are 0 .. total-1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            wait_reg  <= 1'b0;
            found_reg <= 1'b0;
            slot_reg  <= '0;
            key_reg   <= '0;
        end
        else if (start)
        begin
            key_reg   <= key;
            found_reg <= 1'b0;
            slot_reg  <= '0;
            if (key == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                wait_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            idx_reg  <= CW'(idx_reg + 1'b1);
            wait_reg <= 1'b1;
            if (hit)
            begin
                busy_reg  <= 1'b0;
                found_reg <= 1'b1;
                slot_reg  <= AW'(idx_reg - 1'b1);
            end
            else if (at_end)
            begin
                busy_reg <= 1'b0;
                if (total_reg < CW'(DEPTH))
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= total_reg[AW-1:0];
                    total_reg <= CW'(total_reg + 1'b1);
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign found  = found_reg;
    assign slot   = slot_reg;
    assign rd_key = mem_q;

endmodule

// ----- sv/lock_ownership_tracker.sv -----
// The key tables that a request uses are searched together, one entry per
// cycle, from their memories, then the state entries are read and, for lock
// and unlock updates, modified and written, and a highest query scans the
// held bits one per cycle from the top, stopping at the first held one. The
// owner and wanted keys are captured in the done state. A new request is
// accepted only once the previous response has been taken.
// ----------------------------------------------------------------------------
// lock_ownership_tracker
// Tracks which thread holds which lock with two insert-or-find key tables.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lock_ownership_tracker
    import lot_pkg::*;
#(
    parameter int THREAD_SLOTS = 16,
    parameter int LOCK_SLOTS   = 32,
    parameter int KEY_BITS     = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    lot_if.sink   req,
    lot_if.source rsp
);

    localparam int TW = $clog2(THREAD_SLOTS);
    localparam int LW = $clog2(LOCK_SLOTS);

    state_t state_reg, state_next;
    req_t   req_reg;
    rsp_t   rsp_reg;
    logic   rsp_valid_reg;
    logic   use_t, use_l, t_start, l_start;
    logic   t_busy, l_busy, t_found, l_found;
    logic [TW-1:0] t_slot, t_rd;
    logic [LW-1:0] l_slot, l_rd;
    logic [KEY_BITS-1:0] t_rd_key, l_rd_key;
    logic [KEY_BITS-1:0] tkey, lkey;
    op_t  op;

    // Per-thread and per-lock state memories, packed as one word each.
    logic [LOCK_SLOTS+LW:0] thr_mem [THREAD_SLOTS];
    logic [TW:0]            lck_mem [LOCK_SLOTS];
    logic [LOCK_SLOTS+LW:0] thr_q;
    logic [TW:0]            lck_q;
    logic [THREAD_SLOTS-1:0] thr_vld_reg;
    logic [LOCK_SLOTS-1:0]   lck_vld_reg;
    logic [LOCK_SLOTS+LW:0] thr_cur;
    logic [TW:0]            lck_cur;
    logic [LW:0]            scan_reg;

    assign op    = op_t'(req_reg.operation);
    assign tkey  = req.data.thread_key[KEY_BITS-1:0];
    assign lkey  = req.data.lock_key[KEY_BITS-1:0];
    assign use_t = (req.data.operation != OP_OWNER);
    assign use_l = (req.data.operation != OP_WANTED) && (req.data.operation != OP_HIGHEST);
    assign t_start = req.valid && req.ready && use_t;
    assign l_start = req.valid && req.ready && use_l;

    lot_key_table #(.DEPTH(THREAD_SLOTS), .KEY_BITS(KEY_BITS)) u_thr (
        .clk, .rst_n, .start(t_start), .key(tkey), .busy(t_busy),
        .found(t_found), .slot(t_slot), .rd_addr(t_rd), .rd_key(t_rd_key)
    );
    lot_key_table #(.DEPTH(LOCK_SLOTS), .KEY_BITS(KEY_BITS)) u_lck (
        .clk, .rst_n, .start(l_start), .key(lkey), .busy(l_busy),
        .found(l_found), .slot(l_slot), .rd_addr(l_rd), .rd_key(l_rd_key)
    );

    logic tf, lf;
    assign tf = t_found && (op != OP_OWNER);
    assign lf = l_found && (op != OP_WANTED) && (op != OP_HIGHEST);

    // Key reads for owner and wanted queries.
    assign t_rd = lck_cur[TW-1:0];
    assign l_rd = thr_cur[LW-1:0];

    // Entries never written read as their reset value.
    assign thr_cur = thr_vld_reg[t_slot] ? thr_q : '0;
    assign lck_cur = lck_vld_reg[l_slot] ? lck_q : '0;

    // State memory reads and updates.
    always_ff @(posedge clk)
    begin
        thr_q <= thr_mem[t_slot];
        lck_q <= lck_mem[l_slot];
        if (state_reg == ST_UPDATE && tf && lf)
        begin
            if (op == OP_LOCK_TRY)
            begin
                thr_mem[t_slot] <= {thr_cur[LOCK_SLOTS+LW:LW+1], 1'b1, l_slot};
            end
            else if (op == OP_LOCK_DONE && req_reg.success)
            begin
                thr_mem[t_slot] <= {thr_cur[LOCK_SLOTS+LW:LW+1] | LOCK_SLOTS'(1) << l_slot,
                                    1'b0, thr_cur[LW-1:0]};
                lck_mem[l_slot] <= {1'b1, t_slot};
            end
            else if (op == OP_UNLOCK_DONE && req_reg.success)
            begin
                thr_mem[t_slot] <= {thr_cur[LOCK_SLOTS+LW:LW+1] & ~(LOCK_SLOTS'(1) << l_slot),
                                    thr_cur[LW:0]};
                lck_mem[l_slot] <= '0;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (req.valid && req.ready) state_next = ST_SEARCH;
            ST_SEARCH: if (!t_busy && !l_busy) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = (op == OP_HIGHEST) ? ST_SCAN : ST_DONE;
            ST_SCAN:   if (scan_reg == '0 || thr_cur[LW + scan_reg]) state_next = ST_DONE;
            ST_DONE:   if (!rsp_valid_reg || rsp.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE) && !rsp_valid_reg;

    // Sequencer, valid bits and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            thr_vld_reg   <= '0;
            lck_vld_reg   <= '0;
            scan_reg      <= '0;
            req_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && state_next == ST_IDLE)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (req.valid && req.ready)
            begin
                req_reg <= req.data;
            end
            if (state_reg == ST_UPDATE)
            begin
                scan_reg <= (LW+1)'(LOCK_SLOTS);
                rsp_reg.thread_slot   <= tf ? OUT_TSLOT_BITS'(t_slot) : '0;
                rsp_reg.thread_found  <= tf;
                rsp_reg.lock_slot     <= lf ? OUT_LSLOT_BITS'(l_slot) : '0;
                rsp_reg.lock_found    <= lf;
                rsp_reg.held          <= (op == OP_HELD && tf && lf) ?
                                         thr_cur[LW + 1 + l_slot] : 1'b0;
                rsp_reg.owner_valid   <= (op == OP_OWNER) && lf && lck_cur[TW];
                rsp_reg.owner_thread  <= '0;
                rsp_reg.wanted_valid  <= (op == OP_WANTED) && tf && thr_cur[LW];
                rsp_reg.wanted_lock   <= '0;
                rsp_reg.highest_valid <= 1'b0;
                rsp_reg.highest_slot  <= '0;
                if (tf && lf)
                begin
                    if (op == OP_LOCK_TRY ||
                        ((op == OP_LOCK_DONE || op == OP_UNLOCK_DONE) && req_reg.success))
                    begin
                        thr_vld_reg[t_slot] <= 1'b1;
                    end
                    if ((op == OP_LOCK_DONE || op == OP_UNLOCK_DONE) && req_reg.success)
                    begin
                        lck_vld_reg[l_slot] <= 1'b1;
                    end
                end
            end
            if (state_reg == ST_SCAN && scan_reg != '0)
            begin
                if (tf && thr_cur[LW + scan_reg])
                begin
                    rsp_reg.highest_valid <= 1'b1;
                    rsp_reg.highest_slot  <= OUT_LSLOT_BITS'(scan_reg - 1'b1);
                end
                scan_reg <= (LW+1)'(scan_reg - 1'b1);
            end
            // The key read addressed in the update cycle arrives now.
            if (state_reg == ST_DONE)
            begin
                if (op == OP_OWNER && rsp_reg.owner_valid)
                begin
                    rsp_reg.owner_thread <= FIELD_KEY_BITS'(t_rd_key);
                end
                if (op == OP_WANTED && rsp_reg.wanted_valid)
                begin
                    rsp_reg.wanted_lock <= FIELD_KEY_BITS'(l_rd_key);
                end
            end
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, req.ready, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_accept_search, clk, rst_n, req.valid && req.ready, state_reg == ST_SEARCH)
    `ASSERT_IMPLIES(a_found_slot, clk, rst_n, rsp.valid && !rsp.data.thread_found,
                    rsp.data.thread_slot == '0)

endmodule

// ----- bench/lock_ownership_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lock_ownership_checker
// Watches the request and response channels of the lock ownership tracker,
// keeps its own copy of the thread and lock tables, and compares every
// response with the oldest predicted one.
// ----------------------------------------------------------------------------
module lock_ownership_checker
    import lot_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp_data,
    output int   fail_count,
    output int   pending_count
);

    localparam int NT = 16;
    localparam int NL = 32;

    logic [63:0] t_keys [NT];
    logic        t_used [NT];
    logic [31:0] held_mask [NT];
    logic [4:0]  want_slot [NT];
    logic        want_flag [NT];
    logic [63:0] l_keys [NL];
    logic        l_used [NL];
    logic [3:0]  own_slot [NL];
    logic        own_flag [NL];

    rsp_t expected_rsp [$];

    // Clear the model tables to their state after reset.
    task automatic clear_tables();
        for (int i = 0; i < NT; i++)
        begin
            t_keys[i] = '0;
            t_used[i] = 1'b0;
            held_mask[i] = '0;
            want_slot[i] = '0;
            want_flag[i] = 1'b0;
        end
        for (int i = 0; i < NL; i++)
        begin
            l_keys[i] = '0;
            l_used[i] = 1'b0;
            own_slot[i] = '0;
            own_flag[i] = 1'b0;
        end
    endtask

    // Find a thread key or insert it in the lowest free slot.
    task automatic find_thread(input logic [63:0] key, output logic found,
                               output logic [3:0] slot);
        found = 1'b0;
        slot = '0;
        if (key != 0)
        begin
            for (int i = 0; i < NT && !found; i++)
                if (t_used[i] && t_keys[i] == key)
                begin
                    found = 1'b1;
                    slot = i[3:0];
                end
            for (int i = 0; i < NT && !found; i++)
                if (!t_used[i])
                begin
                    t_used[i] = 1'b1;
                    t_keys[i] = key;
                    found = 1'b1;
                    slot = i[3:0];
                end
        end
    endtask

    // Find a lock key or insert it in the lowest free slot.
    task automatic find_lock(input logic [63:0] key, output logic found,
                             output logic [4:0] slot);
        found = 1'b0;
        slot = '0;
        if (key != 0)
        begin
            for (int i = 0; i < NL && !found; i++)
                if (l_used[i] && l_keys[i] == key)
                begin
                    found = 1'b1;
                    slot = i[4:0];
                end
            for (int i = 0; i < NL && !found; i++)
                if (!l_used[i])
                begin
                    l_used[i] = 1'b1;
                    l_keys[i] = key;
                    found = 1'b1;
                    slot = i[4:0];
                end
        end
    endtask

    // Apply one request to the model and return the response it causes.
    task automatic track_request(input req_t rq, output rsp_t rs);
        op_t op;
        logic tf, lf;
        logic [3:0] ts;
        logic [4:0] ls;
        op = op_t'(rq.operation);
        rs = '0;
        tf = 1'b0;
        lf = 1'b0;
        ts = '0;
        ls = '0;
        if (op != OP_OWNER)
            find_thread(rq.thread_key, tf, ts);
        if (op != OP_WANTED && op != OP_HIGHEST)
            find_lock(rq.lock_key, lf, ls);
        case (op)
            OP_LOCK_TRY:
                if (tf && lf)
                begin
                    want_slot[ts] = ls;
                    want_flag[ts] = 1'b1;
                end
            OP_LOCK_DONE:
                if (tf && lf && rq.success)
                begin
                    own_slot[ls] = ts;
                    own_flag[ls] = 1'b1;
                    want_flag[ts] = 1'b0;
                    held_mask[ts][ls] = 1'b1;
                end
            OP_UNLOCK_DONE:
                if (tf && lf && rq.success)
                begin
                    own_slot[ls] = '0;
                    own_flag[ls] = 1'b0;
                    held_mask[ts][ls] = 1'b0;
                end
            OP_HELD:
                if (tf && lf)
                    rs.held = held_mask[ts][ls];
            OP_OWNER:
                if (lf && own_flag[ls])
                begin
                    rs.owner_valid = 1'b1;
                    rs.owner_thread = t_keys[own_slot[ls]];
                end
            OP_WANTED:
                if (tf && want_flag[ts])
                begin
                    rs.wanted_valid = 1'b1;
                    rs.wanted_lock = l_keys[want_slot[ts]];
                end
            OP_HIGHEST:
                if (tf)
                    for (int i = 0; i < NL; i++)
                        if (held_mask[ts][i])
                        begin
                            rs.highest_valid = 1'b1;
                            rs.highest_slot = i[4:0];
                        end
            default:
                ;
        endcase
        rs.thread_slot = ts;
        rs.thread_found = tf;
        rs.lock_slot = ls;
        rs.lock_found = lf;
    endtask

    assign pending_count = expected_rsp.size();

    // Predict on every accepted request, compare on every accepted response.
    always @(posedge clk)
    begin
        rsp_t pred;
        rsp_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            clear_tables();
            expected_rsp.delete();
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                track_request(req_data, pred);
                expected_rsp.push_back(pred);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp_data !== want)
                    begin
                        $display("%0t: response mismatch expected %h actual %h",
                                 $time, want, rsp_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- bench/lock_ownership_tracker_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lock_ownership_tracker_test
// Drives directed and random lock, unlock and query requests into the
// tracker with random gaps and response stalls; the checker compares.
// ----------------------------------------------------------------------------
module lock_ownership_tracker_test;
    import lot_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;

    lot_if #(.T(req_t)) req ();
    lot_if #(.T(rsp_t)) rsp ();

    lock_ownership_tracker DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    lock_ownership_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_data      (req.data),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_data      (rsp.data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Small key pools so that most requests reuse known threads and locks.
    logic [63:0] thread_pool [20];
    logic [63:0] lock_pool [40];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Send one request, holding it until it is accepted. The caller drops
    // valid when no request follows.
    task automatic send_request(input op_t op, input logic [63:0] tk,
                                input logic [63:0] lk, input logic ok);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.data <= {op, tk, lk, ok};
        req.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    function automatic logic [63:0] any_key();
        return {$urandom, $urandom};
    endfunction

    // Pick a thread or lock key, mostly from the pool.
    function automatic logic [63:0] pick_thread();
        return ($urandom_range(0, 15) == 0) ? any_key()
                                            : thread_pool[$urandom_range(0, 19)];
    endfunction

    function automatic logic [63:0] pick_lock();
        return ($urandom_range(0, 15) == 0) ? any_key()
                                            : lock_pool[$urandom_range(0, 39)];
    endfunction

    // Receiver holds ready low for a random stall before each response.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            @(negedge clk);
        end
    end

    // Overall time limit.
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [63:0] tk;
        logic [63:0] lk;
        op_t op;
        req.valid = 1'b0;
        req.data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < 20; i++)
            thread_pool[i] = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : any_key() | 64'h1;
        for (int i = 0; i < 40; i++)
            lock_pool[i] = (i == 0) ? 64'h1 : any_key() | 64'h1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme keys, zero keys, every operation.
        send_request(OP_LOCK_TRY, thread_pool[0], lock_pool[0], 1'b0);
        send_request(OP_WANTED, thread_pool[0], '0, 1'b0);
        send_request(OP_LOCK_DONE, thread_pool[0], lock_pool[0], 1'b0);
        send_request(OP_LOCK_DONE, thread_pool[0], lock_pool[0], 1'b1);
        send_request(OP_HELD, thread_pool[0], lock_pool[0], 1'b0);
        send_request(OP_OWNER, '0, lock_pool[0], 1'b0);
        send_request(OP_HIGHEST, thread_pool[0], '0, 1'b0);
        send_request(OP_LOCK_DONE, 64'h1, lock_pool[0], 1'b1);
        send_request(OP_UNLOCK_TRY, thread_pool[0], lock_pool[0], 1'b1);
        send_request(OP_UNLOCK_DONE, thread_pool[0], lock_pool[0], 1'b0);
        send_request(OP_UNLOCK_DONE, thread_pool[0], lock_pool[0], 1'b1);
        send_request(OP_OWNER, 64'h5, lock_pool[0], 1'b1);
        send_request(OP_HELD, '0, '0, 1'b1);
        send_request(OP_LOCK_TRY, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_request(OP_HIGHEST, '0, 64'h7, 1'b0);
        send_request(OP_WANTED, 64'h1, 64'h3, 1'b1);
        req.valid <= 1'b0;

        // Wait for every expected response before the random part.
        while (pending_count != 0)
            @(negedge clk);

        // Random: attempt/result pairs mixed with single random requests on mostly
        // pooled keys; the pools overflow both tables so the full-table case is reached.
        for (int n = 0; n < 650; n++)
        begin
            tk = pick_thread();
            lk = pick_lock();
            if ($urandom_range(0, 31) == 0)
                tk = '0;
            if ($urandom_range(0, 31) == 0)
                lk = '0;
            if ($urandom_range(0, 2) == 0)
            begin
                op = ($urandom_range(0, 1) == 0) ? OP_LOCK_TRY : OP_UNLOCK_TRY;
                send_request(op, tk, lk, 1'($urandom_range(0, 1)));
                send_request(op_t'(op + 3'd1), tk, lk, $urandom_range(0, 3) != 0);
                n++;
            end
            else
                send_request(op_t'($urandom_range(0, 7)), tk, lk, 1'($urandom_range(0, 1)));
        end
        req.valid <= 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lot_pkg.sv
sv/lot_if.sv
sv/lot_key_table.sv
sv/lock_ownership_tracker.sv
bench/lock_ownership_checker.sv
bench/lock_ownership_tracker_test.sv
